// ----- src/tbu_pkg.sv -----
// Shared types and constants for the countdown timer bank.
`default_nettype none
package tbu_pkg;

  // Width of the fired and pending event masks on the result beat
  localparam int MASK_BITS = 8;

  // Command codes
  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_START   = 3'd1,
    FUNC_ADD     = 3'd2,
    FUNC_READ    = 3'd3,
    FUNC_HOLD    = 3'd4,
    FUNC_STOP    = 3'd5,
    FUNC_CLEAR   = 3'd6,
    FUNC_SERVICE = 3'd7
  } func_e;

  // Time base codes for start
  typedef enum logic [1:0] {
    BASE_TICKS   = 2'd0,
    BASE_TENTHS  = 2'd1,
    BASE_SECONDS = 2'd2,
    BASE_MINUTES = 2'd3
  } base_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_TENTHS  = 2'd0;
  localparam logic [1:0] CFG_SECONDS = 2'd1;
  localparam logic [1:0] CFG_MINUTES = 2'd2;

  localparam logic [15:0] TENTHS_RESET  = 16'd100;
  localparam logic [15:0] SECONDS_RESET = 16'd1000;
  localparam logic [15:0] MINUTES_RESET = 16'd60000;
  localparam logic [15:0] SCALE_UNITY   = 16'd1;

  typedef struct packed {
    logic        we;
    logic [1:0]  idx;
    logic [15:0] data;
  } cfg_wr_t;

  // Command as it travels along the chain
  typedef struct packed {
    func_e       func;
    logic [2:0]  channel;
    logic [15:0] amount;
    logic        hold;
  } cmd_t;

  // Result fields gathered cell by cell
  typedef struct packed {
    logic [MASK_BITS-1:0] pending_mask;
    logic [MASK_BITS-1:0] fired_mask;
    logic [15:0]          count_value;
  } acc_t;

endpackage
`default_nettype wire

// ----- src/tbu_front.sv -----
// Front stage: scale registers, time base scaling with saturation, command register.
`default_nettype none
module tbu_front #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire logic                  valid_i,
  input  wire tbu_pkg::cmd_t         cmd_i,
  input  wire logic [1:0]            time_base_i,
  input  wire tbu_pkg::cfg_wr_t      cfg_i,
  output logic                       valid_o,
  output tbu_pkg::cmd_t              cmd_o,
  output logic [COUNT_BITS-1:0]      load_o
);

  localparam int PROD_W = 32;
  localparam logic [PROD_W-1:0] PROD_LIMIT = PROD_W'({COUNT_BITS{1'b1}});

  logic [15:0] tenths_q, seconds_q, minutes_q;
  logic [15:0] scale;
  logic [PROD_W-1:0] product;
  logic [COUNT_BITS-1:0] load_d, load_q;
  logic valid_q;
  tbu_pkg::cmd_t cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tenths_q  <= tbu_pkg::TENTHS_RESET;
      seconds_q <= tbu_pkg::SECONDS_RESET;
      minutes_q <= tbu_pkg::MINUTES_RESET;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        tbu_pkg::CFG_TENTHS:  tenths_q  <= cfg_i.data;
        tbu_pkg::CFG_SECONDS: seconds_q <= cfg_i.data;
        tbu_pkg::CFG_MINUTES: minutes_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (time_base_i)
      tbu_pkg::BASE_TENTHS:  scale = tenths_q;
      tbu_pkg::BASE_SECONDS: scale = seconds_q;
      tbu_pkg::BASE_MINUTES: scale = minutes_q;
      default:               scale = tbu_pkg::SCALE_UNITY;
    endcase
    product = PROD_W'(cmd_i.amount) * PROD_W'(scale);
    // clamp to the count range
    if (product > PROD_LIMIT) begin
      load_d = '1;
    end else begin
      load_d = product[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cmd_q  <= cmd_i;
      load_q <= load_d;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;
  assign load_o  = load_q;

endmodule
`default_nettype wire

// ----- src/tbu_cell.sv -----
// One timer channel cell: holds its count, pause and event, applies a passing command.
`default_nettype none
module tbu_cell #(
  parameter int COUNT_BITS = 16,
  parameter int IDX        = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire logic                  valid_i,
  input  wire tbu_pkg::cmd_t         cmd_i,
  input  wire logic [COUNT_BITS-1:0] load_i,
  input  wire tbu_pkg::acc_t         acc_i,
  output logic                       valid_o,
  output tbu_pkg::cmd_t              cmd_o,
  output logic [COUNT_BITS-1:0]      load_o,
  output tbu_pkg::acc_t              acc_o
);

  localparam int EXT_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int SUM_W = EXT_W + 1;
  localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'({COUNT_BITS{1'b1}});
  localparam bit IN_MASK = IDX < tbu_pkg::MASK_BITS;
  localparam logic [2:0] BIT_POS = 3'(IDX % tbu_pkg::MASK_BITS);

  logic [COUNT_BITS-1:0] cnt_d, cnt_q;
  logic pend_d, pend_q, pause_d, pause_q;
  logic valid_q;
  tbu_pkg::cmd_t cmd_q;
  logic [COUNT_BITS-1:0] load_q;
  tbu_pkg::acc_t acc_d, acc_q;
  logic [EXT_W-1:0] cnt_ext;
  logic [SUM_W-1:0] sum;
  logic hit;

  always_comb begin
    cnt_ext = EXT_W'(cnt_q);
    sum     = SUM_W'(cnt_ext) + SUM_W'(cmd_i.amount);
    hit     = IN_MASK && (cmd_i.channel == BIT_POS);
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    pause_d = pause_q;
    acc_d   = acc_i;
    if (valid_i) begin
      case (cmd_i.func)
        tbu_pkg::FUNC_TICK: begin
          if (cnt_q != '0 && !pause_q) begin
            cnt_d = cnt_q - COUNT_BITS'(1);
            if (cnt_q == COUNT_BITS'(1)) pend_d = 1'b1;
          end
        end
        tbu_pkg::FUNC_START: begin
          if (hit) begin
            if (load_i != '0) begin
              cnt_d   = load_i;
              pend_d  = 1'b0;
              pause_d = 1'b0;
            end else begin
              cnt_d  = '0;
              pend_d = 1'b1;
            end
          end
        end
        tbu_pkg::FUNC_ADD: begin
          if (hit) begin
            cnt_d = (sum > SUM_LIMIT) ? '1 : sum[COUNT_BITS-1:0];
          end
        end
        tbu_pkg::FUNC_READ: begin
          if (hit) acc_d.count_value = cnt_ext[15:0];
        end
        tbu_pkg::FUNC_HOLD: begin
          if (hit) pause_d = cmd_i.hold;
        end
        tbu_pkg::FUNC_STOP: begin
          if (hit) begin
            cnt_d   = '0;
            pend_d  = 1'b0;
            pause_d = 1'b0;
          end
        end
        tbu_pkg::FUNC_CLEAR: begin
          cnt_d   = '0;
          pend_d  = 1'b0;
          pause_d = 1'b0;
        end
        tbu_pkg::FUNC_SERVICE: begin
          if (IN_MASK) acc_d.fired_mask[BIT_POS] = pend_q;
          pend_d = 1'b0;
        end
        default: ;
      endcase
      if (IN_MASK) acc_d.pending_mask[BIT_POS] = pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      pause_q <= 1'b0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      pause_q <= pause_d;
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cmd_q  <= cmd_i;
      load_q <= load_i;
      acc_q  <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;
  assign load_o  = load_q;
  assign acc_o   = acc_q;

endmodule
`default_nettype wire

// ----- src/multi_channel_countdown_timer_bank_unit.sv -----
// Top level of the countdown timer bank: front stage, chain of channel cells, result port.
`default_nettype none
// A bank of NUM_CHANNELS countdown timers driven by one command per input beat
// (tick, start, add, read, set hold, stop, clear all, service); every command
// yields exactly one result beat carrying the read count, the events taken by
// service and the pending events after the command. Each channel lives in its
// own cell of a chain; a command enters a front stage that scales the start
// amount by the selected time base (saturating to the count range) and then
// walks the chain one cell per cycle, each cell applying it to its own channel
// and adding its bits to the result fields. A command is registered in the
// front stage and in every cell, and the result beat comes from the last
// cell. Up to NUM_CHANNELS + 1 commands are in flight, so one command per cycle
// is taken while the result side keeps up; a stalled result beat holds the whole
// chain, and s_axis_tready follows it. Scale registers are written through the
// plain write port and apply to commands accepted after the write.
module multi_channel_countdown_timer_bank_unit #(
  parameter int NUM_CHANNELS = 8,
  parameter int COUNT_BITS   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write: index 0 tenths, 1 seconds, 2 minutes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: channel[2:0], amount[18:3], time_base[20:19], hold[21], zero[23:22]
  input  wire logic [23:0] s_axis_tdata,
  // tuser: func[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: count_value[15:0], fired_mask[23:16], pending_mask[31:24]
  output logic [31:0]      m_axis_tdata
);

  logic adv;
  tbu_pkg::cmd_t   in_cmd;
  tbu_pkg::cfg_wr_t cfg_wr;

  logic                  chain_valid [NUM_CHANNELS+1];
  tbu_pkg::cmd_t         chain_cmd   [NUM_CHANNELS+1];
  logic [COUNT_BITS-1:0] chain_load  [NUM_CHANNELS+1];
  tbu_pkg::acc_t         chain_acc   [NUM_CHANNELS+1];

  // Advance the whole chain unless a result beat waits on the output
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Unpack the input beat
  assign in_cmd.func    = tbu_pkg::func_e'(s_axis_tuser);
  assign in_cmd.channel = s_axis_tdata[2:0];
  assign in_cmd.amount  = s_axis_tdata[18:3];
  assign in_cmd.hold    = s_axis_tdata[21];

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_data_i;

  tbu_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (s_axis_tvalid),
    .cmd_i       (in_cmd),
    .time_base_i (s_axis_tdata[20:19]),
    .cfg_i       (cfg_wr),
    .valid_o     (chain_valid[0]),
    .cmd_o       (chain_cmd[0]),
    .load_o      (chain_load[0])
  );

  // Result fields start empty and fill as the command passes each cell
  assign chain_acc[0] = '0;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
    tbu_cell #(
      .COUNT_BITS (COUNT_BITS),
      .IDX        (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (chain_valid[g]),
      .cmd_i   (chain_cmd[g]),
      .load_i  (chain_load[g]),
      .acc_i   (chain_acc[g]),
      .valid_o (chain_valid[g+1]),
      .cmd_o   (chain_cmd[g+1]),
      .load_o  (chain_load[g+1]),
      .acc_o   (chain_acc[g+1])
    );
  end

  // The last cell's registers are the output register
  assign m_axis_tvalid = chain_valid[NUM_CHANNELS];
  assign m_axis_tdata  = {chain_acc[NUM_CHANNELS].pending_mask,
                          chain_acc[NUM_CHANNELS].fired_mask,
                          chain_acc[NUM_CHANNELS].count_value};

`ifndef SYNTHESIS
  // Only service hands over events
  a_fired_only_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && chain_cmd[NUM_CHANNELS].func != tbu_pkg::FUNC_SERVICE
    |-> m_axis_tdata[23:16] == '0)
    else $error("fired mask set outside service");

  // Only read reports a count
  a_count_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && chain_cmd[NUM_CHANNELS].func != tbu_pkg::FUNC_READ
    |-> m_axis_tdata[15:0] == '0)
    else $error("count value set outside read");

  // Service and clear all leave no event pending
  a_no_pending_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (chain_cmd[NUM_CHANNELS].func == tbu_pkg::FUNC_SERVICE ||
                      chain_cmd[NUM_CHANNELS].func == tbu_pkg::FUNC_CLEAR)
    |-> m_axis_tdata[31:24] == '0)
    else $error("event pending after service or clear all");

  // A stalled result keeps its command in the last cell
  a_stall_holds_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(chain_cmd[NUM_CHANNELS]))
    else $error("last cell command changed under stall");
`endif

endmodule
`default_nettype wire
